// File: hw/rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared types, constants and helpers for the matrix multiply block
// Holds the store geometry, operand widths, payload structs and the
// fixed-point scale-and-saturate step used on each accumulated dot product.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int DIM        = 8;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int IDX_W  = $clog2(DIM);
  localparam int ADDR_W = $clog2(DIM * DIM);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

  typedef enum logic [1:0] {
    ACT_WR_A = 2'd0,
    ACT_WR_B = 2'd1,
    ACT_MUL  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic [0:0] {
    STATUS_OK       = 1'b0,
    STATUS_MISMATCH = 1'b1
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [15:0] product;
    logic               status;
    logic               last;
  } out_item_t;

  // Map a dimension register to the index of its last row or column.
  // Zero counts as one, anything above DIM counts as DIM.
  function automatic logic [IDX_W-1:0] clamp_last(logic [3:0] v);
    logic [IDX_W-1:0] r;
    if (v == 4'd0) begin
      r = '0;
    end else if (v > 4'(DIM)) begin
      r = IDX_W'(DIM - 1);
    end else begin
      r = IDX_W'(v - 4'd1);
    end
    return r;
  endfunction

  // Row-major store address.
  function automatic logic [ADDR_W-1:0] store_addr(logic [2:0] r, logic [2:0] c);
    return ADDR_W'(r * DIM + c);
  endfunction

  // Keep a 16-bit written value in DATA_WIDTH bits (truncate or sign-extend).
  function automatic logic signed [DATA_WIDTH-1:0] load_value(logic signed [15:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  // Floor shift by the fraction width, then saturate to DATA_WIDTH bits.
  function automatic logic signed [15:0] scale_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    q  = acc >>> FRAC_BITS;
    hi = ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    lo = ~hi;
    if (q > hi) begin
      r = hi;
    end else if (q < lo) begin
      r = lo;
    end else begin
      r = q;
    end
    return r[15:0];
  endfunction

endpackage

// File: hw/rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: C = A * B over signed Q8.8 operands
// Element loads go into two row-major stores; a multiply transaction walks
// C column by column, rows inner, with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) carries one transaction:
//   write an A element, write a B element, or start a multiply. Writes emit
//   nothing. A multiply emits m*p results on the out
//   channel (out_valid_o/out_ready_i/out_data_o), column-major, the final one
//   marked with last. If a_cols differs from b_rows (after clamping to
//   1..DIM) a single result with status set and last set is emitted instead.
//   Each product element is built on the shared MAC by a store read, a
//   multiply and an accumulate per inner step, then a load of the output
//   register; in_ready_o stays low while a multiply runs. Only one
//   multiply is in flight at a time.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset sets all dimension registers to 8 and returns to idle; store
//   contents are undefined until written. Configuration writes (cfg_we_i)
//   take effect on the next cycle and must only occur while idle.
// ----------------------------------------------------------------------------
module matrix_multiply (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mm_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mm_pkg::out_item_t out_data_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_ERR  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  logic [mm_pkg::IDX_W-1:0] m_last_q, m_last_d;
  logic [mm_pkg::IDX_W-1:0] n_last_q, n_last_d;
  logic [mm_pkg::IDX_W-1:0] p_last_q, p_last_d;
  logic [mm_pkg::IDX_W-1:0] i_q, i_d;
  logic [mm_pkg::IDX_W-1:0] j_q, j_d;
  logic [mm_pkg::IDX_W-1:0] u_q, u_d;

  logic signed [mm_pkg::DATA_WIDTH-1:0] a_mem [mm_pkg::DIM*mm_pkg::DIM];
  logic signed [mm_pkg::DATA_WIDTH-1:0] b_mem [mm_pkg::DIM*mm_pkg::DIM];
  logic signed [mm_pkg::DATA_WIDTH-1:0] a_rd_q, b_rd_q;
  logic [mm_pkg::ADDR_W-1:0]            a_raddr, b_raddr, waddr;
  logic signed [mm_pkg::DATA_WIDTH-1:0] wvalue;
  logic                                 wr_a, wr_b;

  logic signed [mm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [mm_pkg::ACC_W-1:0]  acc_q, acc_d;

  logic              out_valid_q, out_valid_d;
  mm_pkg::out_item_t out_q, out_d;

  logic in_fire, in_in_range, out_free, last_elem;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_elem   = (u_q == p_last_q) && (i_q == m_last_q);

  assign in_in_range = ({1'b0, in_data_i.row} < 4'(mm_pkg::DIM)) &&
                       ({1'b0, in_data_i.col} < 4'(mm_pkg::DIM));
  assign waddr   = mm_pkg::store_addr(in_data_i.row, in_data_i.col);
  assign wvalue  = mm_pkg::load_value(in_data_i.value);
  assign wr_a    = in_fire && in_in_range && (in_data_i.action == mm_pkg::ACT_WR_A);
  assign wr_b    = in_fire && in_in_range && (in_data_i.action == mm_pkg::ACT_WR_B);
  assign a_raddr = mm_pkg::store_addr(3'(i_q), 3'(j_q));
  assign b_raddr = mm_pkg::store_addr(3'(j_q), 3'(u_q));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= 4'd8;
      a_cols_q <= 4'd8;
      b_rows_q <= 4'd8;
      b_cols_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mm_pkg::REG_A_ROWS: a_rows_q <= cfg_wdata_i;
        mm_pkg::REG_A_COLS: a_cols_q <= cfg_wdata_i;
        mm_pkg::REG_B_ROWS: b_rows_q <= cfg_wdata_i;
        mm_pkg::REG_B_COLS: b_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Operand stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[waddr] <= wvalue;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      b_mem[waddr] <= wvalue;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  // Sequencer and shared MAC
  always_comb begin
    state_d     = state_q;
    m_last_d    = m_last_q;
    n_last_d    = n_last_q;
    p_last_d    = p_last_q;
    i_d         = i_q;
    j_d         = j_q;
    u_d         = u_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_data_i.action == mm_pkg::ACT_MUL)) begin
          m_last_d = mm_pkg::clamp_last(a_rows_q);
          n_last_d = mm_pkg::clamp_last(a_cols_q);
          p_last_d = mm_pkg::clamp_last(b_cols_q);
          i_d      = '0;
          j_d      = '0;
          u_d      = '0;
          acc_d    = '0;
          if (mm_pkg::clamp_last(a_cols_q) != mm_pkg::clamp_last(b_rows_q)) begin
            state_d = ST_ERR;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = a_rd_q * b_rd_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + mm_pkg::ACC_W'(prod_q);
        if (j_q == n_last_q) begin
          state_d = ST_OUT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        // Hold until the output register frees up
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.out_row = 3'(i_q);
          out_d.out_col = 3'(u_q);
          out_d.product = mm_pkg::scale_sat(acc_q);
          out_d.status  = mm_pkg::STATUS_OK;
          out_d.last    = last_elem;
          acc_d         = '0;
          j_d           = '0;
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            if (i_q == m_last_q) begin
              i_d = '0;
              u_d = u_q + 1'b1;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.out_row = '0;
          out_d.out_col = '0;
          out_d.product = '0;
          out_d.status  = mm_pkg::STATUS_MISMATCH;
          out_d.last    = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      m_last_q    <= '0;
      n_last_q    <= '0;
      p_last_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      u_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      m_last_q    <= m_last_d;
      n_last_q    <= n_last_d;
      p_last_q    <= p_last_d;
      i_q         <= i_d;
      j_q         <= j_d;
      u_q         <= u_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  // A multiply transaction blocks the input side on the following cycle
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.action == mm_pkg::ACT_MUL)) |=> !in_ready_o)
    else $error("input accepted right after a multiply transaction");

  // An error result is always the final one of its run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == mm_pkg::STATUS_MISMATCH)) |-> out_data_o.last)
    else $error("mismatch result without last");

  // The inner index never runs past the inner dimension
  a_inner_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (j_q <= n_last_q))
    else $error("inner index beyond inner dimension");

  // Output register never overwritten while a stalled result waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q == ST_OUT || state_q == ST_ERR))
      |=> (state_q == $past(state_q)))
    else $error("sequencer advanced while output stalled");

endmodule

// File: tb/sv/tb_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply: self-checking testbench for the matrix multiply block
// Loads A and B elements over the input channel, issues multiply
// transactions under many dimension settings, predicts every product element
// in a scoreboard and checks each output transaction in order. Both sides
// idle at random; one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_matrix_multiply;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 310;
  // unused action code, ignored by the block
  localparam logic [1:0] ACT_NOP = 2'd3;

  class product_scoreboard;
    logic signed [15:0] a_mat [mm_pkg::DIM*mm_pkg::DIM];
    logic signed [15:0] b_mat [mm_pkg::DIM*mm_pkg::DIM];
    logic [3:0]         dim_reg [4];
    mm_pkg::out_item_t  expected_q [$];
    int                 mismatches;

    function new();
      foreach (dim_reg[k]) dim_reg[k] = 4'd8;
      foreach (a_mat[k]) begin
        a_mat[k] = '0;
        b_mat[k] = '0;
      end
      mismatches = 0;
    endfunction

    function int used_dim(mm_pkg::cfg_reg_e r);
      if (dim_reg[r] == 4'd0) return 1;
      if (dim_reg[r] > mm_pkg::DIM) return mm_pkg::DIM;
      return int'(dim_reg[r]);
    endfunction

    function void note_input(mm_pkg::in_item_t it);
      int                m;
      int                n;
      int                p;
      longint            acc;
      longint            q;
      longint            hi;
      longint            lo;
      mm_pkg::out_item_t e;
      case (it.action)
        mm_pkg::ACT_WR_A: a_mat[it.row * mm_pkg::DIM + it.col] = it.value;
        mm_pkg::ACT_WR_B: b_mat[it.row * mm_pkg::DIM + it.col] = it.value;
        mm_pkg::ACT_MUL: begin
          m = used_dim(mm_pkg::REG_A_ROWS);
          n = used_dim(mm_pkg::REG_A_COLS);
          p = used_dim(mm_pkg::REG_B_COLS);
          if (n != used_dim(mm_pkg::REG_B_ROWS)) begin
            e        = '0;
            e.status = mm_pkg::STATUS_MISMATCH;
            e.last   = 1'b1;
            expected_q.push_back(e);
          end else begin
            hi = (longint'(1) <<< (mm_pkg::DATA_WIDTH - 1)) - 1;
            lo = -hi - 1;
            // walk C column by column, rows inner
            for (int u = 0; u < p; u++) begin
              for (int i = 0; i < m; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++)
                  acc += longint'(a_mat[i*mm_pkg::DIM + j]) *
                         longint'(b_mat[j*mm_pkg::DIM + u]);
                // floor shift, then clamp to the output range
                q = acc >>> mm_pkg::FRAC_BITS;
                if (q > hi) q = hi;
                else if (q < lo) q = lo;
                e.out_row = 3'(i);
                e.out_col = 3'(u);
                e.product = 16'(q);
                e.status  = mm_pkg::STATUS_OK;
                e.last    = (u == p - 1) && (i == m - 1);
                expected_q.push_back(e);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(mm_pkg::out_item_t got);
      mm_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d col %0d product %0d status %0d last %0d",
                   got.out_row, got.out_col, got.product, got.status, got.last);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected row %0d col %0d product %0d status %0d last %0d",
                   e.out_row, e.out_col, e.product, e.status, e.last);
          $display("               got row %0d col %0d product %0d status %0d last %0d",
                   got.out_row, got.out_col, got.product, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [3:0]        cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  mm_pkg::in_item_t  in_data;
  logic              out_valid;
  logic              out_ready;
  mm_pkg::out_item_t out_data;

  product_scoreboard sb;
  bit a_loaded [mm_pkg::DIM*mm_pkg::DIM];
  bit b_loaded [mm_pkg::DIM*mm_pkg::DIM];
  bit steady;
  bit hold_req;
  int items_sent;

  matrix_multiply u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [15:0] pick_value();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2, 3, 4: v = 16'($urandom_range(0, 1023) - 512);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(mm_pkg::in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (it.action != ACT_NOP) items_sent++;
  endtask

  task automatic write_elem(logic [1:0] act, int r, int c, logic signed [15:0] v);
    mm_pkg::in_item_t it;
    it.action = act;
    it.row    = 3'(r);
    it.col    = 3'(c);
    it.value  = v;
    send_item(it);
    if (act == mm_pkg::ACT_WR_A) a_loaded[r*mm_pkg::DIM + c] = 1'b1;
    else if (act == mm_pkg::ACT_WR_B) b_loaded[r*mm_pkg::DIM + c] = 1'b1;
  endtask

  task automatic run_product(int refresh);
    int               m;
    int               n;
    int               p;
    mm_pkg::in_item_t it;
    m = sb.used_dim(mm_pkg::REG_A_ROWS);
    n = sb.used_dim(mm_pkg::REG_A_COLS);
    p = sb.used_dim(mm_pkg::REG_B_COLS);
    if (n == sb.used_dim(mm_pkg::REG_B_ROWS)) begin
      // load every operand the product will read that is still unwritten
      for (int i = 0; i < m; i++)
        for (int j = 0; j < n; j++)
          if (!a_loaded[i*mm_pkg::DIM + j])
            write_elem(mm_pkg::ACT_WR_A, i, j, pick_value());
      for (int j = 0; j < n; j++)
        for (int u = 0; u < p; u++)
          if (!b_loaded[j*mm_pkg::DIM + u])
            write_elem(mm_pkg::ACT_WR_B, j, u, pick_value());
      repeat (refresh) begin
        if ($urandom_range(0, 1))
          write_elem(mm_pkg::ACT_WR_A, $urandom_range(0, m - 1), $urandom_range(0, n - 1),
                     pick_value());
        else
          write_elem(mm_pkg::ACT_WR_B, $urandom_range(0, n - 1), $urandom_range(0, p - 1),
                     pick_value());
      end
    end
    it.action = mm_pkg::ACT_MUL;
    it.row    = 3'($urandom);
    it.col    = 3'($urandom);
    it.value  = 16'($urandom);
    send_item(it);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_dims(int vals [4]);
    foreach (vals[k]) begin
      @(negedge clk);
      cfg_we       = 1'b1;
      cfg_idx      = mm_pkg::cfg_reg_e'(k);
      cfg_wdata    = 4'(vals[k]);
      sb.dim_reg[k] = 4'(vals[k]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // receiver: random stalls per transaction, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int random_base;
    int phase;
    int sel;
    int dv [4];
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = mm_pkg::REG_A_ROWS;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // saturation both ways, floor rounding, ignored action, mismatch, clamping
    set_dims('{1, 1, 1, 1});
    write_elem(mm_pkg::ACT_WR_A, 0, 0, 16'sh8000);
    write_elem(mm_pkg::ACT_WR_B, 0, 0, 16'sh8000);
    run_product(0);
    write_elem(mm_pkg::ACT_WR_B, 0, 0, 16'sh7FFF);
    run_product(0);
    write_elem(mm_pkg::ACT_WR_A, 0, 0, -16'sd1);
    write_elem(mm_pkg::ACT_WR_B, 0, 0, 16'sd1);
    run_product(0);
    write_elem(ACT_NOP, 7, 7, 16'sh5A5A);
    settle();
    set_dims('{1, 2, 1, 1});
    run_product(0);
    settle();
    set_dims('{1, 1, 1, 15});
    run_product(0);

    random_base = items_sent;
    phase       = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0:       dv = '{8, 8, 8, 8};
        1:       dv = '{0, 0, 0, 0};
        2:       dv = '{15, 9, 12, 15};
        3:       dv = '{8, 1, 1, 8};
        default: begin
          foreach (dv[k])
            dv[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 4);
          // keep the inner dimensions agreeing most of the time
          if ($urandom_range(0, 3) != 0) dv[2] = dv[1];
        end
      endcase
      set_dims(dv);
      steady = (phase % 3 == 2);
      if (phase == 0) begin
        // stall the receiver mid-product while writes keep coming
        hold_req = 1'b1;
        run_product(0);
      end
      repeat ($urandom_range(4, 10)) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)
          write_elem(ACT_NOP, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
        else if (sel <= 3)
          write_elem($urandom_range(0, 1) ? mm_pkg::ACT_WR_B : mm_pkg::ACT_WR_A,
                     $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
        else
          run_product($urandom_range(0, 3));
      end
      phase++;
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mm_pkg.sv
hw/rtl/matrix_multiply.sv
tb/sv/tb_matrix_multiply.sv
